// ===== hw/rtl/spt_pkg.sv =====
// Shared constants and types for the stride prefetch table.
package spt_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int AddrW = 32;
  localparam int StrideW = 11;
  localparam int BlkW = 10;
  localparam int BlkLsb = 4;
  localparam int LineShift = 5;
  localparam int QDepth = 2;

  localparam logic [1:0] ModeInit   = 2'd0;
  localparam logic [1:0] ModeTrans  = 2'd1;
  localparam logic [1:0] ModeSteady = 2'd2;
  localparam logic [1:0] ModeNopred = 2'd3;

  localparam logic ActAccess = 1'b0;
  localparam logic ActDone   = 1'b1;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] pc;
    logic [AddrW-1:0] addr;
  } item_t;

endpackage

// ===== hw/rtl/spt_front.sv =====
// Input stage: accepts beats and queues them for the table engine.
module spt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  spt_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output spt_pkg::item_t q_item
);

  localparam int PtrW = $clog2(spt_pkg::QDepth);

  spt_pkg::item_t    mem [spt_pkg::QDepth];
  logic [PtrW-1:0]   wptr;
  logic [PtrW-1:0]   rptr;
  logic [PtrW:0]     count;
  logic              push;
  logic              pop;

  assign in_ready = (count != (PtrW+1)'(spt_pkg::QDepth));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/spt_engine.sv =====
// Table engine: serial PC search, entry update and prefetch issue.
module spt_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  spt_pkg::item_t            q_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [spt_pkg::AddrW-1:0] prefetch_addr
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StRead   = 2'd2;
  localparam logic [1:0] StUpdate = 2'd3;

  localparam int EntW = spt_pkg::AddrW + spt_pkg::StrideW + 2;
  localparam logic [spt_pkg::CntW-1:0] ScanEnd = spt_pkg::CntW'(spt_pkg::TableEntries + 1);

  logic [EntW-1:0]            ram [spt_pkg::TableEntries];
  logic [spt_pkg::TableEntries-1:0] valid;
  logic [spt_pkg::AddrW-1:0]  pc_tag [spt_pkg::TableEntries];

  logic [1:0]                 state;
  logic [spt_pkg::CntW-1:0]   scan;
  logic                       hit;
  logic [spt_pkg::IdxW-1:0]   hit_idx;
  logic                       have_free;
  logic [spt_pkg::IdxW-1:0]   free_idx;
  spt_pkg::item_t             cur;
  logic                       pending;
  logic [EntW-1:0]            rd;
  logic [spt_pkg::IdxW-1:0]   sidx;
  logic [spt_pkg::IdxW-1:0]   tidx;
  logic [spt_pkg::AddrW-1:0]  tag_rd;

  logic [spt_pkg::AddrW-1:0]   e_last;
  logic [spt_pkg::StrideW-1:0] e_stride;
  logic [1:0]                  e_mode;
  logic [spt_pkg::BlkW-1:0]    cidx;
  logic [spt_pkg::BlkW-1:0]    pidx;
  logic [spt_pkg::StrideW-1:0] diff;
  logic                        match;
  logic [1:0]                  mode_next;
  logic [spt_pkg::StrideW-1:0] stride_next;
  logic [spt_pkg::AddrW-1:0]   pf;

  assign sidx = scan[spt_pkg::IdxW-1:0];
  assign tidx = sidx - 1'b1;
  assign q_ready = (state == StIdle) && !out_valid;
  assign {e_last, e_stride, e_mode} = rd;

  assign cidx = cur.addr[spt_pkg::BlkLsb +: spt_pkg::BlkW];
  assign pidx = e_last[spt_pkg::BlkLsb +: spt_pkg::BlkW];
  assign diff = {1'b0, cidx} - {1'b0, pidx};
  assign match = (diff == e_stride);
  assign pf = cur.addr + {{(spt_pkg::AddrW-spt_pkg::StrideW-spt_pkg::LineShift)
              {e_stride[spt_pkg::StrideW-1]}}, e_stride, {spt_pkg::LineShift{1'b0}}};

  always_comb begin
    stride_next = e_stride;
    mode_next   = e_mode;
    if (match) begin
      mode_next = (e_mode == spt_pkg::ModeNopred) ? spt_pkg::ModeTrans : spt_pkg::ModeSteady;
    end else begin
      unique case (e_mode)
        spt_pkg::ModeInit: begin
          stride_next = diff;
          mode_next   = spt_pkg::ModeTrans;
        end
        spt_pkg::ModeSteady: begin
          mode_next = spt_pkg::ModeInit;
        end
        default: begin
          stride_next = diff;
          mode_next   = spt_pkg::ModeNopred;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd     <= ram[hit_idx];
    tag_rd <= pc_tag[sidx];
    if (state == StIdle && q_valid && q_ready) begin
      cur <= q_item;
    end
    if (state == StScan && scan == ScanEnd && !hit && have_free) begin
      ram[free_idx]    <= {cur.addr, {spt_pkg::StrideW{1'b0}}, spt_pkg::ModeInit};
      pc_tag[free_idx] <= cur.pc;
    end
    if (state == StUpdate) begin
      ram[hit_idx] <= {cur.addr, stride_next, mode_next};
    end
    if (state == StUpdate && e_mode == spt_pkg::ModeSteady) begin
      prefetch_addr <= pf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      valid     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      scan      <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      hit_idx   <= '0;
      free_idx  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (q_valid && q_ready) begin
            if (q_item.action == spt_pkg::ActDone) begin
              pending <= 1'b0;
            end else if (!pending) begin
              state     <= StScan;
              scan      <= '0;
              hit       <= 1'b0;
              have_free <= 1'b0;
            end
          end
        end
        StScan: begin
          if (scan == ScanEnd) begin
            if (hit) begin
              state <= StRead;
            end else begin
              if (have_free) begin
                valid[free_idx] <= 1'b1;
              end
              state <= StIdle;
            end
          end else begin
            if (scan != '0) begin
              if (valid[tidx]) begin
                if (!hit && tag_rd == cur.pc) begin
                  hit     <= 1'b1;
                  hit_idx <= tidx;
                end
              end else if (!have_free) begin
                have_free <= 1'b1;
                free_idx  <= tidx;
              end
            end
            scan <= scan + 1'b1;
          end
        end
        StRead: begin
          state <= StUpdate;
        end
        StUpdate: begin
          if (e_mode == spt_pkg::ModeSteady) begin
            pending   <= 1'b1;
            out_valid <= 1'b1;
          end
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/stride_prefetch_table.sv =====
// Stride prefetch table top level: input queue feeding the table engine.
// Input channel (in_valid/in_ready) carries beats of action, access_pc and
// access_addr. action 1 marks completion of the outstanding prefetch and
// clears the pending flag; action 0 is a CPU access.
// An access seen while a prefetch is pending is dropped. Otherwise
// the PC is searched over the 64-entry table one entry per cycle through a
// registered tag read.
// A hit on a steady entry issues one beat on the output channel
// (out_valid/out_ready) carrying prefetch_addr. Other accesses produce no beat.
// A two-entry queue in front keeps accepting beats while the engine works.
// The engine holds a finished beat until out_ready; it takes no new item
// while a beat is held, so a stalled receiver eventually fills the queue
// and drops in_ready.
// Reset clears the table valid bits, the pending flag and both channels.
module stride_prefetch_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] access_pc,
  input  logic [31:0] access_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] prefetch_addr
);

  spt_pkg::item_t in_item;
  spt_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  assign in_item = '{action: action, pc: access_pc, addr: access_addr};

  spt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  spt_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .prefetch_addr (prefetch_addr)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prefetch_addr))
    else $error("prefetch beat changed while stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready)
    else $error("queue popped while result held");

  a_no_pop_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule
